[design/isolated_pixel_checker_core_macros.svh]
// Assertion helpers used by the core design file.
`ifndef ISOLATED_PIXEL_CHECKER_CORE_MACROS_SVH
`define ISOLATED_PIXEL_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ipc_pkg.sv]
package ipc_pkg;

    // Register map
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Stored width of a size register
    localparam int CFG_FIELD_W = 7;

    // APB address width (two word registers)
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // One column entry of the previous row
    typedef struct packed {
        logic set;   // pixel was set
        logic pend;  // set pixel still lacking a neighbor
    } t_line_entry;

endpackage

[design/ipc_cfg.sv]
module ipc_cfg import ipc_pkg::*; #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int SZW        = 7,
    parameter int SZH        = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic [SZW-1:0]    o_width_eff,
    output logic [SZH-1:0]    o_height_eff,
    output logic              o_restart
);

    logic [CFG_FIELD_W-1:0] r_width;
    logic [CFG_FIELD_W-1:0] r_height;
    logic                   wr_en;
    logic [SZW-1:0]         width_ext;
    logic [SZH-1:0]         height_ext;

    assign wr_en     = psel && penable && pwrite;
    assign o_restart = wr_en;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_FIELD_W'(1);
            r_height <= CFG_FIELD_W'(1);
        end else if (wr_en) begin
            case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[CFG_FIELD_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    // Clamp sizes into 1..MAX
    assign width_ext  = SZW'(r_width);
    assign height_ext = SZH'(r_height);

    always_comb begin
        if (width_ext == '0) begin
            o_width_eff = SZW'(1);
        end else if (width_ext > SZW'(MAX_WIDTH)) begin
            o_width_eff = SZW'(MAX_WIDTH);
        end else begin
            o_width_eff = width_ext;
        end
        if (height_ext == '0) begin
            o_height_eff = SZH'(1);
        end else if (height_ext > SZH'(MAX_HEIGHT)) begin
            o_height_eff = SZH'(MAX_HEIGHT);
        end else begin
            o_height_eff = height_ext;
        end
    end

endmodule

[design/ipc_line_buf.sv]
module ipc_line_buf import ipc_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_line_entry i_wdata,
    input  logic        i_re,
    input  logic [AW-1:0] i_raddr,
    output t_line_entry o_rdata
);

    t_line_entry r_mem [DEPTH];
    t_line_entry r_q;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, new data forwarded on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_q <= i_wdata;
            end else begin
                r_q <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_q;

endmodule

[design/isolated_pixel_checker_core.sv]
// Channel   | Direction | Handshake                      | Payload
// ----------+-----------+--------------------------------+--------------------
// pixel in  | input     | i_in_valid / o_in_ready        | i_is_set
// verdict   | output    | o_out_valid / i_out_ready      | o_all_have_neighbor
// config    | APB       | psel & penable & pwrite        | paddr, pwdata, prdata
//
// One pixel per cycle; each pixel does one read and at most one write of the
// line buffer, the read for the next column issued at the accept edge.
// The verdict is registered and appears the cycle after the last pixel.
// Input stalls only while a verdict waits and i_out_ready is low.
// Reset is synchronous; the line buffer needs no clearing (row 0 never reads it).
`include "isolated_pixel_checker_core_macros.svh"

module isolated_pixel_checker_core import ipc_pkg::*; #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_is_set,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_all_have_neighbor
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SZW   = ($clog2(MAX_WIDTH + 1) > CFG_FIELD_W) ?
                           $clog2(MAX_WIDTH + 1) : CFG_FIELD_W;
    localparam int SZH   = ($clog2(MAX_HEIGHT + 1) > CFG_FIELD_W) ?
                           $clog2(MAX_HEIGHT + 1) : CFG_FIELD_W;

    logic [SZW-1:0]   w_eff;
    logic [SZH-1:0]   h_eff;
    logic             restart;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_left_set;
    logic             r_left_pend;
    logic             r_failed, n_failed;
    logic             r_out_valid;
    logic             r_out_bit;
    t_line_entry      r_tail;

    logic             in_acc;
    logic             last_col, last_row;
    logic             row_nz, col_nz;
    t_line_entry      mem_q;
    t_line_entry      up_e;
    logic             up, up_pend, left, left_pend, pend;
    logic             fail_now;
    logic             mem_we;
    logic [COL_W-1:0] mem_waddr;
    t_line_entry      mem_wdata;

    assign pready = 1'b1;

    // Size registers
    ipc_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SZW        (SZW),
        .SZH        (SZH)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .o_width_eff  (w_eff),
        .o_height_eff (h_eff),
        .o_restart    (restart)
    );

    // Previous-row buffer, all columns but the last
    ipc_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_acc),
        .i_raddr (n_col),
        .o_rdata (mem_q)
    );

    // Handshake
    assign o_in_ready          = !r_out_valid || i_out_ready;
    assign in_acc              = i_in_valid && o_in_ready;
    assign o_out_valid         = r_out_valid;
    assign o_all_have_neighbor = r_out_bit;

    // Position decode
    assign last_col = ((SZW'(r_col) + SZW'(1)) == w_eff);
    assign last_row = ((SZH'(r_row) + SZH'(1)) == h_eff);
    assign row_nz   = (r_row != '0);
    assign col_nz   = (r_col != '0);

    // Neighbor context: last column lives in the tail register
    assign up_e      = last_col ? r_tail : mem_q;
    assign up        = row_nz && up_e.set;
    assign up_pend   = row_nz && up_e.pend;
    assign left      = col_nz && r_left_set;
    assign left_pend = col_nz && r_left_pend;
    assign pend      = i_is_set && !up && !left;

    // Failure: pixel above left unsupported, left pixel unsupported in the
    // last row, or a lone pixel in the bottom-right corner
    assign fail_now = (up_pend && !i_is_set)
                   || (left_pend && !i_is_set && last_row)
                   || (pend && last_row && last_col);
    assign n_failed = r_failed || fail_now;

    // Left column's entry is final once its right neighbor is seen
    assign mem_we          = in_acc && col_nz;
    assign mem_waddr       = r_col - COL_W'(1);
    assign mem_wdata.set   = r_left_set;
    assign mem_wdata.pend  = r_left_pend && !i_is_set;

    // Next position
    always_comb begin
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_left_set  <= 1'b0;
            r_left_pend <= 1'b0;
            r_failed    <= 1'b0;
        end else if (restart) begin
            r_col       <= '0;
            r_row       <= '0;
            r_left_set  <= 1'b0;
            r_left_pend <= 1'b0;
            r_failed    <= 1'b0;
        end else if (in_acc) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_left_set  <= i_is_set;
            r_left_pend <= pend;
            r_failed    <= (last_col && last_row) ? 1'b0 : n_failed;
        end
    end

    // Last column has no right neighbor, so its entry is final at once
    always_ff @(posedge i_clk) begin
        if (in_acc && last_col) begin
            r_tail.set  <= i_is_set;
            r_tail.pend <= pend;
        end
    end

    // Verdict register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && last_col && last_row) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && last_col && last_row) begin
            r_out_bit <= !n_failed;
        end
    end

    // Checks
    `IPC_ASSERT_NOW(a_col_range, 1'b1, SZW'(r_col) < w_eff, "column beyond image width")
    `IPC_ASSERT_NOW(a_row_range, 1'b1, SZH'(r_row) < h_eff, "row beyond image height")
    `IPC_ASSERT_NEXT(a_verdict, in_acc && last_col && last_row, r_out_valid, "verdict missing")
    `IPC_ASSERT_NOW(a_no_wr_col0, in_acc && !col_nz, !mem_we, "line write at column zero")

endmodule

[test/isolated_pixel_checker_core_tb.sv]
`timescale 1ns / 1ps

module isolated_pixel_checker_core_tb import ipc_pkg::*;;

    localparam int MAX_W        = 64;
    localparam int MAX_H        = 64;
    localparam int PIXEL_BUDGET = 1850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic              i_is_set    = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_all_have_neighbor;

    isolated_pixel_checker_core #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_is_set           (i_is_set),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_all_have_neighbor(o_all_have_neighbor)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Neighbor-check predictor state
    logic [CFG_FIELD_W-1:0] width_cfg  = 7'd1;
    logic [CFG_FIELD_W-1:0] height_cfg = 7'd1;
    t_line_entry            line_prev [MAX_W];
    int unsigned            row_pos    = 0;
    int unsigned            col_pos    = 0;
    bit                     left_set   = 1'b0;
    bit                     left_pend  = 1'b0;
    bit                     image_failed = 1'b0;

    bit          verdict_q [$];   // expected verdicts, oldest first
    bit          pixel_q [$];     // pixels waiting for the driver
    int unsigned pushed_pixels = 0;
    int unsigned err_count     = 0;
    int unsigned cycle_count   = 0;
    bit          in_acc        = 1'b0;
    bit          no_idle       = 1'b0;
    int          in_gap        = 0;
    int          out_gap       = 0;
    int          hold_left     = 0;
    int          hold_reqs     = 0;
    int          holds_served  = 0;

    function automatic int unsigned eff_size(logic [CFG_FIELD_W-1:0] v, int unsigned lim);
        if (v == '0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic void restart_image();
        row_pos      = 0;
        col_pos      = 0;
        left_set     = 1'b0;
        left_pend    = 1'b0;
        image_failed = 1'b0;
    endfunction

    // Advance the neighbor check by one pixel; queue a verdict on the last one
    function automatic void track_pixel(bit px);
        int unsigned w, h, r, c;
        bit last_row, last_col, up, up_pend, lft, lft_pend, pend;
        w = eff_size(width_cfg, MAX_W);
        h = eff_size(height_cfg, MAX_H);
        r = row_pos;
        c = col_pos;
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        last_row = (r + 1 == h);
        last_col = (c + 1 == w);
        up       = (r > 0) && line_prev[c].set;
        up_pend  = (r > 0) && line_prev[c].pend;
        lft      = (c > 0) && left_set;
        lft_pend = (c > 0) && left_pend;
        // pending pixel above is decided by this one
        if (up_pend && !px) image_failed = 1'b1;
        // pending pixel on the left is decided by this one
        if (lft_pend) begin
            if (px) line_prev[c-1].pend = 1'b0;
            else if (last_row) image_failed = 1'b1;
        end
        pend = px && !up && !lft;
        if (pend && last_row && last_col) image_failed = 1'b1;
        line_prev[c].set  = px;
        line_prev[c].pend = pend;
        left_set  = px;
        left_pend = pend;
        if (last_col) begin
            if (last_row) begin
                verdict_q.push_back(!image_failed);
                restart_image();
            end else begin
                col_pos = 0;
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    task automatic report_mismatch(string what);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Pixel driver: one transaction per handshake, random gaps between them until no_idle is set
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !in_acc)) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                i_in_valid <= 1'b1;
                i_is_set   <= pixel_q.pop_front();
                if (!no_idle && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 8);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Verdict receiver: short random stalls until no_idle is set, plus requested long hold-offs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_reqs != holds_served) begin
            holds_served++;
            hold_left = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 8);
        end
    end

    // Monitor: predict on accepted pixels, check accepted verdicts
    always @(posedge i_clk) begin
        bit exp_v;
        in_acc <= i_rst_n && i_in_valid && o_in_ready;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("isolated_pixel_checker_core regression: fail");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && o_in_ready) track_pixel(i_is_set);
            if (o_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("verdict transaction with none expected");
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (o_all_have_neighbor !== exp_v)
                        report_mismatch($sformatf("all_have_neighbor got %b expected %b",
                                                  o_all_have_neighbor, exp_v));
                end
            end
        end
    end

    // Wait until every pixel is taken and every verdict has come, then let it settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || i_in_valid || verdict_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic cfg_write(logic reg_idx, logic [CFG_FIELD_W-1:0] val);
        logic [APB_DW-1:0] noise;
        logic [APB_DW-1:0] rd;
        noise = $urandom;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {noise[APB_DW-1:CFG_FIELD_W], val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_WIDTH) width_cfg = val;
        else height_cfg = val;
        restart_image();
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== APB_DW'(val))
            report_mismatch($sformatf("reg %0d read %h expected %h", reg_idx, rd, val));
    endtask

    task automatic set_size(logic [CFG_FIELD_W-1:0] w, logic [CFG_FIELD_W-1:0] h);
        wait_idle();
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
    endtask

    // Queue n pixels, MSB first
    task automatic push_pixels(logic [63:0] bits, int n);
        for (int i = n - 1; i >= 0; i--) pixel_q.push_back(bits[i]);
        pushed_pixels += n;
    endtask

    // One random image of w x h pixels
    task automatic gen_image(int unsigned w, int unsigned h);
        bit          img [MAX_H][MAX_W];
        int unsigned mode, dens, r, c, n, pat;
        foreach (img[i, j]) img[i][j] = 1'b0;
        mode = $urandom_range(0, 5);
        case (mode)
            0, 1: begin
                // random fill at a random density
                dens = $urandom_range(1, 7);
                for (int i = 0; i < h; i++)
                    for (int j = 0; j < w; j++)
                        img[i][j] = ($urandom_range(0, 7) < dens);
            end
            2, 3, 4: begin
                // dominoes never leave a pixel alone
                n = $urandom_range(1, (w * h) / 2 + 1);
                for (int k = 0; k < n; k++) begin
                    r = $urandom_range(0, h - 1);
                    c = $urandom_range(0, w - 1);
                    if ($urandom_range(0, 1) && c + 1 < w) begin
                        img[r][c] = 1'b1;
                        img[r][c+1] = 1'b1;
                    end else if (r + 1 < h) begin
                        img[r][c] = 1'b1;
                        img[r+1][c] = 1'b1;
                    end else if (c + 1 < w) begin
                        img[r][c] = 1'b1;
                        img[r][c+1] = 1'b1;
                    end
                end
                // then one lone pixel, often at an edge or corner
                if (mode == 4) begin
                    r = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 0 : h - 1)
                                             : $urandom_range(0, h - 1);
                    c = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 0 : w - 1)
                                             : $urandom_range(0, w - 1);
                    img[r][c] = 1'b1;
                    if (r > 0)     img[r-1][c] = 1'b0;
                    if (r + 1 < h) img[r+1][c] = 1'b0;
                    if (c > 0)     img[r][c-1] = 1'b0;
                    if (c + 1 < w) img[r][c+1] = 1'b0;
                end
            end
            default: begin
                // all set, all clear, or checkerboard
                pat = $urandom_range(0, 2);
                for (int i = 0; i < h; i++)
                    for (int j = 0; j < w; j++)
                        img[i][j] = (pat == 0) ? 1'b1 : (pat == 1) ? 1'b0 : ((i + j) % 2 == 0);
            end
        endcase
        for (int i = 0; i < h; i++)
            for (int j = 0; j < w; j++)
                pixel_q.push_back(img[i][j]);
        pushed_pixels += w * h;
    endtask

    function automatic logic [CFG_FIELD_W-1:0] pick_dim();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return '0;
        if (sel == 1) return CFG_FIELD_W'($urandom_range(65, 127));
        if (sel == 2) return CFG_FIELD_W'(MAX_W);
        if (sel <= 5) return CFG_FIELD_W'($urandom_range(1, 2));
        return CFG_FIELD_W'($urandom_range(1, 8));
    endfunction

    // Stimulus sequence
    initial begin
        logic [CFG_FIELD_W-1:0] w_cfg, h_cfg;
        int unsigned w_eff, h_eff, n_img, phase;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset size is 1x1: a lone set pixel fails, a clear one passes
        push_pixels(2'b10, 2);
        // zero sizes act as 1
        set_size(7'd0, 7'd0);
        push_pixels(1'b1, 1);
        // single row: pair, lone left, lone right
        set_size(7'd2, 7'd1);
        push_pixels(6'b111001, 6);
        // 2x2: vertical pair passes, diagonal fails
        set_size(7'd2, 7'd2);
        push_pixels(8'b1010_1001, 8);
        // size write mid-image drops the partial image
        set_size(7'd3, 7'd2);
        push_pixels(4'b1011, 4);
        wait_idle();
        cfg_write(REG_HEIGHT, 7'd2);
        push_pixels(6'b011_110, 6);

        // random phases, extremes of both registers first
        phase = 0;
        while (pushed_pixels < PIXEL_BUDGET) begin
            case (phase)
                0: begin w_cfg = 7'd127; h_cfg = 7'd1;  end
                1: begin w_cfg = 7'd1;   h_cfg = 7'd65; end
                2: begin w_cfg = 7'd64;  h_cfg = 7'd2;  end
                3: begin w_cfg = 7'd2;   h_cfg = 7'd64; end
                4: begin w_cfg = 7'd3;   h_cfg = 7'd3;  end
                default: begin
                    w_cfg = pick_dim();
                    h_cfg = pick_dim();
                    if (eff_size(w_cfg, MAX_W) * eff_size(h_cfg, MAX_H) > 256)
                        h_cfg = CFG_FIELD_W'($urandom_range(1, 3));
                end
            endcase
            w_eff = eff_size(w_cfg, MAX_W);
            h_eff = eff_size(h_cfg, MAX_H);
            set_size(w_cfg, h_cfg);
            // receiver holds off while the sender keeps offering small images
            if (phase == 4 || phase == 15) begin
                hold_reqs++;
                n_img = 12;
            end else if (w_eff * h_eff > 64) begin
                n_img = $urandom_range(1, 2);
            end else begin
                n_img = $urandom_range(2, 8);
            end
            for (int k = 0; k < n_img && pushed_pixels < PIXEL_BUDGET; k++)
                gen_image(w_eff, h_eff);
            if (pushed_pixels >= PIXEL_BUDGET * 4 / 5) no_idle = 1'b1;
            phase++;
        end

        wait_idle();
        if (err_count == 0) begin
            $display("isolated_pixel_checker_core regression: pass");
        end else begin
            $display("isolated_pixel_checker_core regression: fail");
        end
        $finish;
    end

endmodule

[isolated_pixel_checker_core.f]
+incdir+design
design/ipc_pkg.sv
design/ipc_cfg.sv
design/ipc_line_buf.sv
design/isolated_pixel_checker_core.sv
test/isolated_pixel_checker_core_tb.sv
